>>> rtl/hmis_pkg.sv
// Shared types, constants and arithmetic helpers for the height grid smoothing block.
package hmis_pkg;

	localparam int X_BITS      = 8;
	localparam int Y_BITS      = 8;
	localparam int SIZE_BITS   = 9;
	localparam int HEIGHT_BITS = 16;
	localparam int ADDR_BITS   = X_BITS + Y_BITS;
	localparam int MEM_DEPTH   = 1 << ADDR_BITS;

	localparam logic [SIZE_BITS-1:0] MAX_X = SIZE_BITS'(256);
	localparam logic [SIZE_BITS-1:0] MAX_Y = SIZE_BITS'(256);

	// Opcodes of an input item.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	// Configuration register indexes.
	localparam logic REG_X_SIZE = 1'b0;
	localparam logic REG_Y_SIZE = 1'b1;

	typedef struct packed {
		logic [1:0]                    opcode;
		logic [X_BITS-1:0]             x_pos;
		logic [Y_BITS-1:0]             y_pos;
		logic signed [HEIGHT_BITS-1:0] height_in;
	} hmis_in_t;

	typedef struct packed {
		logic signed [HEIGHT_BITS-1:0] height_out;
		logic [1:0]                    op_done;
	} hmis_out_t;

	// One memory access request: a read port and a write port.
	typedef struct packed {
		logic                          re;
		logic [ADDR_BITS-1:0]          raddr;
		logic                          we;
		logic [ADDR_BITS-1:0]          waddr;
		logic signed [HEIGHT_BITS-1:0] wdata;
	} hmis_mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OWN,
		ST_XM,
		ST_XP,
		ST_YP,
		ST_WB
	} hmis_step_t;

	// Average of two heights, truncated toward zero.
	function automatic logic signed [HEIGHT_BITS-1:0] half_avg(
		input logic signed [HEIGHT_BITS-1:0] a,
		input logic signed [HEIGHT_BITS-1:0] b
	);
		logic signed [HEIGHT_BITS:0] sum;
		logic signed [HEIGHT_BITS:0] adj;
		sum = {a[HEIGHT_BITS-1], a} + {b[HEIGHT_BITS-1], b};
		adj = sum + {{HEIGHT_BITS{1'b0}}, sum[HEIGHT_BITS]};
		return adj[HEIGHT_BITS:1];
	endfunction

	// Clamp a size register to the grid dimension.
	function automatic logic [SIZE_BITS-1:0] clamp_size(
		input logic [SIZE_BITS-1:0] size,
		input logic [SIZE_BITS-1:0] limit
	);
		return (size > limit) ? limit : size;
	endfunction

endpackage

>>> rtl/hmis_ram.sv
// Height store: single-port-write, single-port-read synchronous memory.
module hmis_ram (
	input  logic                                   clk,
	input  hmis_pkg::hmis_mem_req_t                req,
	output logic signed [hmis_pkg::HEIGHT_BITS-1:0] rdata
);

	logic signed [hmis_pkg::HEIGHT_BITS-1:0] mem [hmis_pkg::MEM_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Registered read port, holds its data between reads.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

>>> rtl/hmis_smooth.sv
// Smoothing pass sequencer: walks the grid and reads, averages and writes back each cell.
module hmis_smooth (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic [hmis_pkg::SIZE_BITS-1:0]          x_eff,
	input  logic [hmis_pkg::SIZE_BITS-1:0]          y_eff,
	input  logic signed [hmis_pkg::HEIGHT_BITS-1:0] rdata,
	output hmis_pkg::hmis_mem_req_t                 req,
	output logic                                    done
);

	hmis_pkg::hmis_step_t state_q, state_d;

	logic [hmis_pkg::X_BITS-1:0]             i_q;
	logic [hmis_pkg::Y_BITS-1:0]             j_q;
	logic [hmis_pkg::SIZE_BITS-1:0]          xs_q;
	logic [hmis_pkg::SIZE_BITS-1:0]          ys_q;
	logic signed [hmis_pkg::HEIGHT_BITS-1:0] acc_q;
	logic signed [hmis_pkg::HEIGHT_BITS-1:0] prev_q;

	logic [hmis_pkg::SIZE_BITS-1:0]          i_next;
	logic [hmis_pkg::SIZE_BITS-1:0]          j_next;
	logic                                    has_xm, has_xp, has_ym, has_yp;
	logic                                    last_row, last_col;
	logic signed [hmis_pkg::HEIGHT_BITS-1:0] fold_ym;
	logic signed [hmis_pkg::HEIGHT_BITS-1:0] cell_new;

	// Neighbour presence and walk position.
	assign i_next   = {1'b0, i_q} + hmis_pkg::SIZE_BITS'(1);
	assign j_next   = {1'b0, j_q} + hmis_pkg::SIZE_BITS'(1);
	assign has_xm   = (i_q != '0);
	assign has_xp   = (i_next < xs_q);
	assign has_ym   = (j_q != '0);
	assign has_yp   = (j_next < ys_q);
	assign last_row = !has_yp;
	assign last_col = !has_xp;

	// Final two folds of the cell: updated y-1, then original y+1.
	assign fold_ym  = has_ym ? hmis_pkg::half_avg(acc_q, prev_q) : acc_q;
	assign cell_new = has_yp ? hmis_pkg::half_avg(fold_ym, rdata) : fold_ym;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hmis_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory requests.
	always_comb begin
		state_d   = state_q;
		req       = '0;
		req.waddr = {i_q, j_q};
		req.wdata = cell_new;
		req.raddr = {i_q, j_q};
		done      = 1'b0;
		unique case (state_q)
			hmis_pkg::ST_IDLE: begin
				if (start) begin
					state_d = hmis_pkg::ST_OWN;
				end
			end
			hmis_pkg::ST_OWN: begin
				req.re  = 1'b1;
				state_d = hmis_pkg::ST_XM;
			end
			hmis_pkg::ST_XM: begin
				req.re    = has_xm;
				req.raddr = {i_q - hmis_pkg::X_BITS'(1), j_q};
				state_d   = hmis_pkg::ST_XP;
			end
			hmis_pkg::ST_XP: begin
				req.re    = has_xp;
				req.raddr = {i_next[hmis_pkg::X_BITS-1:0], j_q};
				state_d   = hmis_pkg::ST_YP;
			end
			hmis_pkg::ST_YP: begin
				req.re    = has_yp;
				req.raddr = {i_q, j_next[hmis_pkg::Y_BITS-1:0]};
				state_d   = hmis_pkg::ST_WB;
			end
			hmis_pkg::ST_WB: begin
				req.we = 1'b1;
				if (last_row && last_col) begin
					done    = 1'b1;
					state_d = hmis_pkg::ST_IDLE;
				end else begin
					state_d = hmis_pkg::ST_OWN;
				end
			end
			default: begin
				state_d = hmis_pkg::ST_IDLE;
			end
		endcase
	end

	// Walk counters and the running average.
	always_ff @(posedge clk) begin
		case (state_q)
			hmis_pkg::ST_IDLE: begin
				i_q  <= '0;
				j_q  <= '0;
				xs_q <= x_eff;
				ys_q <= y_eff;
			end
			hmis_pkg::ST_XM: begin
				acc_q <= rdata;
			end
			hmis_pkg::ST_XP: begin
				if (has_xm) begin
					acc_q <= hmis_pkg::half_avg(acc_q, rdata);
				end
			end
			hmis_pkg::ST_YP: begin
				if (has_xp) begin
					acc_q <= hmis_pkg::half_avg(acc_q, rdata);
				end
			end
			hmis_pkg::ST_WB: begin
				prev_q <= cell_new;
				if (last_row) begin
					j_q <= '0;
					i_q <= i_next[hmis_pkg::X_BITS-1:0];
				end else begin
					j_q <= j_next[hmis_pkg::Y_BITS-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/heightmap_inplace_smoothing_top.sv
// Top level of the height grid: command port, size registers and store access.
// Write, read, no-op and empty-grid run items: one item per cycle while not busy; the result
// reaches the ports through the command stage and then the result register.
// Run item: busy while the pass walks each cell in use (clamped sizes) with four reads through the
// single read port plus a write-back; the result follows in the cycle after the last cell.
// Reset clears control state and sets both sizes to 256; the store is undefined until written.
module heightmap_inplace_smoothing_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [hmis_pkg::SIZE_BITS-1:0]    cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  hmis_pkg::hmis_in_t                item,
	output logic                              done,
	output hmis_pkg::hmis_out_t               result
);

	logic [hmis_pkg::SIZE_BITS-1:0] x_size_q, y_size_q;
	logic [hmis_pkg::SIZE_BITS-1:0] x_eff, y_eff;
	logic                           run_q;
	logic                           valid_s1;
	logic [1:0]                     op_s1;
	logic                           in_range_s1;
	logic                           accept, in_range;
	logic                           grid_empty, run_go;
	logic                           eng_done;
	logic signed [hmis_pkg::HEIGHT_BITS-1:0] rdata;
	hmis_pkg::hmis_mem_req_t        cmd_req, eng_req, mem_req;

	assign cfg_ready = 1'b1;
	assign busy      = run_q;
	assign accept    = start && !run_q;
	assign x_eff     = hmis_pkg::clamp_size(x_size_q, hmis_pkg::MAX_X);
	assign y_eff     = hmis_pkg::clamp_size(y_size_q, hmis_pkg::MAX_Y);
	assign in_range  = ({1'b0, item.x_pos} < x_eff) && ({1'b0, item.y_pos} < y_eff);

	// A run over an empty grid has nothing to walk and answers through the command stage.
	assign grid_empty = (x_eff == '0) || (y_eff == '0);
	assign run_go     = accept && (item.opcode == hmis_pkg::OP_RUN) && !grid_empty;

	// Size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_size_q <= hmis_pkg::SIZE_BITS'(256);
			y_size_q <= hmis_pkg::SIZE_BITS'(256);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hmis_pkg::REG_X_SIZE: x_size_q <= cfg_data;
				hmis_pkg::REG_Y_SIZE: y_size_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Direct memory access for write and read items.
	always_comb begin
		cmd_req       = '0;
		cmd_req.re    = accept && (item.opcode == hmis_pkg::OP_READ);
		cmd_req.raddr = {item.x_pos, item.y_pos};
		cmd_req.we    = accept && (item.opcode == hmis_pkg::OP_WRITE) && in_range;
		cmd_req.waddr = {item.x_pos, item.y_pos};
		cmd_req.wdata = item.height_in;
	end

	// The pass owns the memory while it runs.
	assign mem_req = run_q ? eng_req : cmd_req;

	hmis_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	hmis_smooth u_smooth (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (run_go),
		.x_eff  (x_eff),
		.y_eff  (y_eff),
		.rdata  (rdata),
		.req    (eng_req),
		.done   (eng_done)
	);

	// Run flag and the command stage that waits for read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (eng_done) begin
				run_q <= 1'b0;
			end else if (run_go) begin
				run_q <= 1'b1;
			end
			valid_s1 <= accept && !run_go;
		end
	end

	always_ff @(posedge clk) begin
		op_s1       <= item.opcode;
		in_range_s1 <= in_range;
	end

	// Result register: one strobe per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= eng_done || valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_done) begin
			result.op_done    <= hmis_pkg::OP_RUN;
			result.height_out <= '0;
		end else begin
			result.op_done    <= op_s1;
			result.height_out <= ((op_s1 == hmis_pkg::OP_READ) && in_range_s1) ? rdata : '0;
		end
	end

endmodule
